### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

### rtl/mpfr_pkg.sv
// shared widths and constants of the median pressure fan regulator
package mpfr_pkg;

  // field widths
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned SAMPLE_W   = 9;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned SET_W      = 8;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned QC_W       = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // derived step widths: max_freq/100 fits 10 bits, times 127 fits 17 bits
  localparam int unsigned UNIT_W = 10;
  localparam int unsigned BIG_W  = 17;

  // scaled magnitude after divide by 240 stays at or below 136
  localparam int unsigned QUOT_W = 8;

  // divide by 240 as multiply by reciprocal, exact for magnitudes up to 32768
  localparam int unsigned      DIV240_SHIFT = 23;
  localparam logic [RAW_W-1:0] DIV240_MUL   = 16'd34953;

  // divide by 20 as multiply by reciprocal, exact for values up to 2584
  localparam int unsigned M19_W       = 12;
  localparam int unsigned DIV20_SHIFT = 16;
  localparam logic [11:0] DIV20_MUL   = 12'd3277;

  // divide by 100 as multiply by reciprocal, exact for 16-bit values
  localparam int unsigned DIV100_SHIFT = 23;
  localparam logic [16:0] DIV100_MUL   = 17'd83887;

  // percent scale: small decrease only when max_freq exceeds it
  localparam logic [FREQ_W-1:0] PCT_SCALE = 16'd100;

  // configuration seen by the command stage
  typedef struct packed {
    logic [SET_W-1:0]  setpoint;
    logic [FREQ_W-1:0] max_freq;
    logic [THR_W-1:0]  threshold;
    logic [UNIT_W-1:0] unit;
    logic [BIG_W-1:0]  big;
  } reg_cfg_t;

endpackage

### rtl/mpfr_if.sv
// valid/ready channels for sample items and result items

interface mpfr_in_if
  import mpfr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] raw_pressure;
  logic                    read_ok;
  logic [FREQ_W-1:0]       drive_frequency;

  modport source (output valid, raw_pressure, read_ok, drive_frequency, input ready);
  modport sink   (input valid, raw_pressure, read_ok, drive_frequency, output ready);
endinterface

interface mpfr_out_if
  import mpfr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] median_pressure;
  logic [FREQ_W-1:0]          new_frequency;
  logic                       command_issued;
  logic                       at_target;

  modport source (output valid, median_pressure, new_frequency, command_issued,
                  at_target, input ready);
  modport sink   (input valid, median_pressure, new_frequency, command_issued,
                  at_target, output ready);
endinterface

### rtl/mpfr_front.sv
// front end: accepts samples, scales them, fills the batch and hands it off
`include "assert_macros.svh"

module mpfr_front
  import mpfr_pkg::*;
#(
  parameter int unsigned SAMPLES = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  mpfr_in_if.sink                              sample_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output logic [SAMPLES*SAMPLE_W+FREQ_W-1:0]   job_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLES);

  // stage one registers
  logic              s1_valid_q;
  logic              s1_neg_q;
  logic [QUOT_W-1:0] s1_quot_q;
  logic [FREQ_W-1:0] s1_freq_q;

  // batch store and fill position
  logic [SAMPLES-1:0][SAMPLE_W-1:0] store_q;
  logic [CNT_W-1:0]                 cnt_q;

  logic signed [RAW_W-1:0]          raw_val;
  logic                             raw_neg;
  logic [RAW_W-1:0]                 raw_mag;
  logic [2*RAW_W-1:0]               prod240;
  logic [QUOT_W-1:0]                quot;
  logic [M19_W-1:0]                 m19;
  logic [M19_W+12-1:0]              prod20;
  logic [SAMPLE_W-1:0]              scaled_pos;
  logic [SAMPLE_W-1:0]              scaled;
  logic                             last;
  logic                             commit;
  logic                             in_ready;
  logic [SAMPLES-1:0][SAMPLE_W-1:0] batch;

  // magnitude divided by 240, truncated toward zero
  always_comb begin
    raw_val = sample_i.read_ok ? sample_i.raw_pressure : '0;
    raw_neg = raw_val[RAW_W-1];
    raw_mag = raw_neg ? (~raw_val + 1'b1) : raw_val;
    prod240 = raw_mag * DIV240_MUL;
    quot    = prod240[DIV240_SHIFT +: QUOT_W];
  end

  // times 19, divided by 20, sign restored
  always_comb begin
    m19 = {s1_quot_q, 4'b0} + {3'b0, s1_quot_q, 1'b0} + {4'b0, s1_quot_q};
    prod20 = m19 * DIV20_MUL;
    scaled_pos = {1'b0, prod20[DIV20_SHIFT +: QUOT_W]};
    scaled = s1_neg_q ? (~scaled_pos + 1'b1) : scaled_pos;
  end

  // the last sample of a batch waits for room in the queue
  assign last     = (cnt_q == CNT_W'(SAMPLES - 1));
  assign commit   = s1_valid_q && (!last || !full_i);
  assign in_ready = !s1_valid_q || commit;
  assign sample_i.ready = in_ready;
  assign push_o   = s1_valid_q && last && !full_i;

  // complete batch with the newest sample merged in
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      batch[i] = (cnt_q == CNT_W'(i)) ? scaled : store_q[i];
    end
  end

  assign job_o = {s1_freq_q, batch};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (commit) begin
        cnt_q <= last ? '0 : cnt_q + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready && sample_i.valid) begin
      s1_neg_q  <= raw_neg;
      s1_quot_q <= quot;
      s1_freq_q <= sample_i.drive_frequency;
    end
    if (commit) begin
      store_q[cnt_q] <= scaled;
    end
  end

  `ASSERT_CLK(front_cnt_range, cnt_q <= CNT_W'(SAMPLES - 1))
  `ASSERT_CLK(front_hold, s1_valid_q && !in_ready |=> s1_valid_q && $stable(s1_quot_q))

endmodule

### rtl/mpfr_queue.sv
// two-entry queue of complete batches between front and back
`include "assert_macros.svh"

module mpfr_queue
  import mpfr_pkg::*;
#(
  parameter int unsigned WIDTH = 106
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      priority if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end else begin
        count_q <= count_q;
      end
    end
  end

  // slot write
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(queue_no_overflow, push_i && full_o)
  `ASSERT_CLK(queue_no_underflow, pop_i |-> valid_o)

endmodule

### rtl/mpfr_back.sv
// back end: median by rank count, then frequency command into the output register
`include "assert_macros.svh"

module mpfr_back
  import mpfr_pkg::*;
#(
  parameter int unsigned SAMPLES = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_valid_i,
  input  logic [SAMPLES*SAMPLE_W+FREQ_W-1:0] job_i,
  output logic                               pop_o,
  input  reg_cfg_t                           cfg_i,
  mpfr_out_if.source                         result_o
);

  localparam int unsigned RANK_W = $clog2(SAMPLES + 1);
  localparam int unsigned MID    = SAMPLES / 2;
  localparam int unsigned DIFF_W = 11;
  localparam int unsigned SUM_W  = 18;

  // median stage
  logic                       b1_valid_q;
  logic signed [SAMPLE_W-1:0] med_q;
  logic [FREQ_W-1:0]          freq_q;

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_med_q;
  logic [FREQ_W-1:0]          out_freq_q;
  logic                       out_issued_q;
  logic                       out_at_q;

  logic signed [SAMPLE_W-1:0] smp [SAMPLES];
  logic [SAMPLES-1:0]         lt_m [SAMPLES];
  logic [SAMPLES-1:0]         le_m [SAMPLES];
  logic [RANK_W-1:0]          lt_cnt [SAMPLES];
  logic [RANK_W-1:0]          le_cnt [SAMPLES];
  logic [SAMPLE_W-1:0]        med_or;

  logic out_free;
  logic b1_adv;
  logic b1_load;

  logic signed [DIFF_W-1:0] tgt_s, med_s, thr_s, err_up, err_dn;
  logic                     below, above;
  logic [SUM_W-1:0]         sum_big, sum_unit;
  logic                     freq_ge_big;
  logic [FREQ_W-1:0]        dec_big;
  logic [FREQ_W-1:0]        small_val;
  logic [FREQ_W-1:0]        cmd;

  function automatic logic [FREQ_W-1:0] clamp_max(input logic [SUM_W-1:0] v,
                                                  input logic [FREQ_W-1:0] mx);
    clamp_max = (v > SUM_W'(mx)) ? mx : v[FREQ_W-1:0];
  endfunction

  // stage handshake
  assign out_free = !out_valid_q || result_o.ready;
  assign b1_adv   = b1_valid_q && out_free;
  assign b1_load  = !b1_valid_q || b1_adv;
  assign pop_o    = job_valid_i && b1_load;

  // pairwise rank: the median has at most MID smaller and more than MID not larger
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      smp[i] = $signed(job_i[i*SAMPLE_W +: SAMPLE_W]);
    end
    for (int i = 0; i < SAMPLES; i++) begin
      for (int j = 0; j < SAMPLES; j++) begin
        lt_m[i][j] = smp[j] <  smp[i];
        le_m[i][j] = smp[j] <= smp[i];
      end
    end
    med_or = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      lt_cnt[i] = RANK_W'($countones(lt_m[i]));
      le_cnt[i] = RANK_W'($countones(le_m[i]));
      // every matching element holds the same value
      if (lt_cnt[i] <= RANK_W'(MID) && le_cnt[i] > RANK_W'(MID)) begin
        med_or = med_or | smp[i];
      end
    end
  end

  // error against setpoint and step candidates
  always_comb begin
    tgt_s  = $signed({{(DIFF_W-SET_W){1'b0}}, cfg_i.setpoint});
    thr_s  = $signed({{(DIFF_W-THR_W){1'b0}}, cfg_i.threshold});
    med_s  = DIFF_W'(med_q);
    below  = med_s < tgt_s;
    above  = med_s > tgt_s;
    err_up = tgt_s - med_s;
    err_dn = med_s - tgt_s;

    sum_big     = SUM_W'(freq_q) + SUM_W'(cfg_i.big);
    sum_unit    = SUM_W'(freq_q) + SUM_W'(cfg_i.unit);
    freq_ge_big = BIG_W'(freq_q) >= cfg_i.big;
    dec_big     = freq_q - cfg_i.big[FREQ_W-1:0];

    // small decrease only when freq*100/max_freq stays below freq
    small_val = '0;
    if (freq_q != '0 && cfg_i.max_freq > PCT_SCALE) begin
      small_val = (freq_q >= FREQ_W'(cfg_i.unit)) ? (freq_q - FREQ_W'(cfg_i.unit)) : '0;
    end

    priority if (below) begin
      cmd = (err_up > thr_s) ? clamp_max(sum_big, cfg_i.max_freq)
                             : clamp_max(sum_unit, cfg_i.max_freq);
    end else if (above) begin
      cmd = (err_dn > thr_s && freq_ge_big) ? clamp_max(SUM_W'(dec_big), cfg_i.max_freq)
                                            : clamp_max(SUM_W'(small_val), cfg_i.max_freq);
    end else begin
      cmd = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b1_load) begin
        b1_valid_q <= job_valid_i;
      end
      if (out_free) begin
        out_valid_q <= b1_valid_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      med_q  <= med_or;
      freq_q <= job_i[SAMPLES*SAMPLE_W +: FREQ_W];
    end
    if (b1_adv) begin
      out_med_q    <= med_q;
      out_freq_q   <= cmd;
      out_issued_q <= below || above;
      out_at_q     <= !(below || above);
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.median_pressure = out_med_q;
  assign result_o.new_frequency   = out_freq_q;
  assign result_o.command_issued  = out_issued_q;
  assign result_o.at_target       = out_at_q;

  `ASSERT_CLK(back_at_target_idle, out_valid_q && out_at_q |-> !out_issued_q && out_freq_q == '0)
  `ASSERT_CLK(back_median_hold, b1_valid_q && !out_free |=> b1_valid_q && $stable(med_q))

endmodule

### rtl/median_pressure_fan_regulator.sv
// top level: configuration registers, front end, batch queue and back end
//
//   channel    dir  handshake          payload
//   sample_i   in   valid / ready      raw_pressure, read_ok, drive_frequency
//   result_o   out  valid / ready      median_pressure, new_frequency,
//                                      command_issued, at_target
//   cfg        in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// one sample item per cycle, except that the last sample of a batch waits while the queue is full
// the last sample of a batch passes the scale stage, then the batch queue, the
// rank-count median stage and the output register before its result leaves
// reset clears the fill count, queue and valid flags and loads the register defaults
// the two-entry batch queue lets the front keep filling while results stall
// after a max_freq or quick_change write the derived steps settle via unit_q, then big_q

module median_pressure_fan_regulator
  import mpfr_pkg::*;
#(
  parameter int unsigned SAMPLES = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mpfr_in_if.sink               sample_i,
  mpfr_out_if.source            result_o
);

  localparam int unsigned JOB_W = SAMPLES * SAMPLE_W + FREQ_W;

  localparam logic [SET_W-1:0]  SETPOINT_RST  = 8'd0;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = 16'd20000;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd10;
  localparam logic [QC_W-1:0]   QUICK_RST     = 7'd10;
  localparam logic [UNIT_W-1:0] UNIT_RST      = 10'd200;
  localparam logic [BIG_W-1:0]  BIG_RST       = 17'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT  = 2'd0,
    CFG_MAX_FREQ  = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_QUICK     = 2'd3
  } cfg_idx_e;

  logic [SET_W-1:0]  setpoint_q;
  logic [FREQ_W-1:0] max_freq_q;
  logic [THR_W-1:0]  threshold_q;
  logic [QC_W-1:0]   quick_q;
  logic [UNIT_W-1:0] unit_q;
  logic [BIG_W-1:0]  big_q;

  logic [FREQ_W+17-1:0] prod100;
  logic                 push;
  logic                 full;
  logic                 pop;
  logic                 job_valid;
  logic [JOB_W-1:0]     job_in;
  logic [JOB_W-1:0]     job_out;
  reg_cfg_t             cfg;

  // max_freq / 100 by reciprocal
  assign prod100 = max_freq_q * DIV100_MUL;

  // register writes and derived step sizes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= SETPOINT_RST;
      max_freq_q  <= MAX_FREQ_RST;
      threshold_q <= THRESHOLD_RST;
      quick_q     <= QUICK_RST;
      unit_q      <= UNIT_RST;
      big_q       <= BIG_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_SETPOINT:  setpoint_q  <= cfg_data_i[SET_W-1:0];
          CFG_MAX_FREQ:  max_freq_q  <= cfg_data_i[FREQ_W-1:0];
          CFG_THRESHOLD: threshold_q <= cfg_data_i[THR_W-1:0];
          CFG_QUICK:     quick_q     <= cfg_data_i[QC_W-1:0];
          default:       ;
        endcase
      end
      unit_q <= prod100[DIV100_SHIFT +: UNIT_W];
      big_q  <= unit_q * quick_q;
    end
  end

  assign cfg = '{setpoint:  setpoint_q,
                 max_freq:  max_freq_q,
                 threshold: threshold_q,
                 unit:      unit_q,
                 big:       big_q};

  mpfr_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .full_i   (full),
    .push_o   (push),
    .job_o    (job_in)
  );

  mpfr_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  mpfr_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .cfg_i       (cfg),
    .result_o    (result_o)
  );

endmodule

### sim/mpfr_tb_pkg.sv
// register indexes shared by the regulator testbench modules
package mpfr_tb_pkg;
  import mpfr_pkg::*;

  // configuration register map, index i is register i
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT,
    REG_MAX_FREQ,
    REG_THRESHOLD,
    REG_QUICK_CHANGE
  } cfg_reg_e;

endpackage

### sim/mpfr_command_checker.sv
// checker: predicts the drive command of every sample batch and compares result items
module mpfr_command_checker
  import mpfr_pkg::*;
  import mpfr_tb_pkg::*;
#(
  parameter int unsigned SAMPLES = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       smp_valid_i,
  input  logic                       smp_ready_i,
  input  logic signed [RAW_W-1:0]    smp_raw_i,
  input  logic                       smp_ok_i,
  input  logic [FREQ_W-1:0]          smp_freq_i,
  input  logic                       res_valid_i,
  input  logic                       res_ready_i,
  input  logic signed [SAMPLE_W-1:0] res_median_i,
  input  logic [FREQ_W-1:0]          res_freq_i,
  input  logic                       res_issued_i,
  input  logic                       res_at_target_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic [FREQ_W-1:0]          frequency;
    logic                       issued;
    logic                       at_target;
  } fan_cmd_t;

  // own copy of the register file
  logic [SET_W-1:0]  setpoint_q;
  logic [FREQ_W-1:0] max_freq_q;
  logic [THR_W-1:0]  threshold_q;
  logic [QC_W-1:0]   quick_q;

  // scaled samples of the batch being gathered
  logic signed [SAMPLE_W-1:0] batch_buf [SAMPLES];
  int unsigned                batch_fill;

  fan_cmd_t expected_commands [$];
  int       fails   = 0;
  int       checked = 0;

  // raw reading to scaled pascal units, both divisions toward zero
  function automatic logic signed [SAMPLE_W-1:0] scale_raw(logic signed [RAW_W-1:0] raw,
                                                          logic ok);
    int v;
    int q;
    v = ok ? int'(raw) : 0;
    q = v / 240;
    return SAMPLE_W'((q * 19) / 20);
  endfunction

  // middle element of the sorted batch
  function automatic int median_of_batch();
    int sorted [SAMPLES];
    int key;
    int j;
    for (int i = 0; i < SAMPLES; i++) sorted[i] = int'(batch_buf[i]);
    for (int i = 1; i < SAMPLES; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    return sorted[SAMPLES / 2];
  endfunction

  function automatic longint limit_to_max(longint v);
    longint mf;
    mf = max_freq_q;
    return (v > mf) ? mf : v;
  endfunction

  // one percent step down, skipped when the percentage is not below the readback
  function automatic longint step_down_small(longint freq);
    longint mf;
    longint pct;
    longint unit_step;
    longint val;
    mf = max_freq_q;
    unit_step = mf / 100;
    val = 0;
    if (mf == 0) begin
      pct = 65535;
    end else begin
      pct = (freq * 100) / mf;
      if (pct > 65535) pct = 65535;
    end
    if (pct < freq) val = (freq >= unit_step) ? freq - unit_step : 0;
    return limit_to_max(val);
  endfunction

  // command derived from the batch median and the readback of the last sample
  function automatic fan_cmd_t predict_command(logic [FREQ_W-1:0] readback);
    fan_cmd_t cmd;
    longint   med;
    longint   target;
    longint   thr;
    longint   freq;
    longint   unit_step;
    longint   big_step;
    longint   value;
    med = median_of_batch();
    target = setpoint_q;
    thr = threshold_q;
    freq = readback;
    unit_step = longint'(max_freq_q) / 100;
    big_step = unit_step * quick_q;
    value = 0;
    cmd.issued = 1'b0;
    cmd.at_target = 1'b0;
    if (med < target) begin
      value = (target - med > thr) ? limit_to_max(freq + big_step)
                                   : limit_to_max(freq + unit_step);
      cmd.issued = 1'b1;
    end else if (med > target) begin
      if (med - target > thr && freq >= big_step) value = limit_to_max(freq - big_step);
      else value = step_down_small(freq);
      cmd.issued = 1'b1;
    end else begin
      cmd.at_target = 1'b1;
    end
    cmd.median = SAMPLE_W'(med);
    cmd.frequency = FREQ_W'(value);
    return cmd;
  endfunction

  // follow register writes, predict on sample items, compare result items
  always @(posedge clk_i or negedge rst_ni) begin
    fan_cmd_t want;
    if (!rst_ni) begin
      setpoint_q  <= '0;
      max_freq_q  <= 16'd20000;
      threshold_q <= 8'd10;
      quick_q     <= 7'd10;
      batch_fill  = 0;
      expected_commands.delete();
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SETPOINT:     setpoint_q  <= cfg_data_i[SET_W-1:0];
          REG_MAX_FREQ:     max_freq_q  <= cfg_data_i[FREQ_W-1:0];
          REG_THRESHOLD:    threshold_q <= cfg_data_i[THR_W-1:0];
          REG_QUICK_CHANGE: quick_q     <= cfg_data_i[QC_W-1:0];
          default: ;
        endcase
      end

      if (res_valid_i && res_ready_i) begin
        if (expected_commands.size() == 0) begin
          $error("result item with no completed batch waiting");
          fails++;
        end else begin
          want = expected_commands.pop_front();
          checked++;
          if (res_median_i !== want.median) begin
            $error("median_pressure: expected %0d, got %0d", want.median, res_median_i);
            fails++;
          end
          if (res_freq_i !== want.frequency) begin
            $error("new_frequency: expected %0d, got %0d", want.frequency, res_freq_i);
            fails++;
          end
          if (res_issued_i !== want.issued) begin
            $error("command_issued: expected %0d, got %0d", want.issued, res_issued_i);
            fails++;
          end
          if (res_at_target_i !== want.at_target) begin
            $error("at_target: expected %0d, got %0d", want.at_target, res_at_target_i);
            fails++;
          end
        end
      end

      if (smp_valid_i && smp_ready_i) begin
        batch_buf[batch_fill] = scale_raw(smp_raw_i, smp_ok_i);
        batch_fill++;
        if (batch_fill == SAMPLES) begin
          batch_fill = 0;
          expected_commands.insert(expected_commands.size(), predict_command(smp_freq_i));
        end
      end

      pending_o <= expected_commands.size();
    end
  end

  assign fail_count_o = fails;
  assign checked_o    = checked;

endmodule

### sim/median_pressure_fan_regulator_test.sv
// testbench top: clock, reset, register settings, sample stimulus and verdict
module median_pressure_fan_regulator_test
  import mpfr_pkg::*;
  import mpfr_tb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLES      = 10;
  localparam int          RESET_CYCLES = 5;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          LONG_STALL_CYCLES = 300;
  localparam int          PHASES       = 10;
  localparam int          PHASE_ITEMS  = 150;
  localparam int          TIMEOUT_NS   = 400_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mpfr_in_if  sample_if ();
  mpfr_out_if result_if ();

  int fail_count;
  int pending_batches;
  int results_checked;

  // settings currently loaded, used to aim the stimulus
  int cur_setpoint  = 0;
  int cur_max_freq  = 20000;
  int cur_threshold = 10;
  int cur_quick     = 10;

  int   items_sent    = 0;
  int   settings_done = 0;
  int   long_stall_req = 0;
  logic no_idle       = 1'b0;

  // corner batch: range ends, divider boundaries, a failed read of full scale
  logic signed [RAW_W-1:0] corner_raw [SAMPLES] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'sd239, -16'sd239,
    16'sd240, -16'sd240, 16'sh7FFF, -16'sd1, 16'sh5555
  };
  logic [SAMPLES-1:0] corner_ok = 10'b1111111101;

  median_pressure_fan_regulator #(
    .SAMPLES(SAMPLES)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .sample_i  (sample_if),
    .result_o  (result_if)
  );

  mpfr_command_checker #(
    .SAMPLES(SAMPLES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .smp_valid_i    (sample_if.valid),
    .smp_ready_i    (sample_if.ready),
    .smp_raw_i      (sample_if.raw_pressure),
    .smp_ok_i       (sample_if.read_ok),
    .smp_freq_i     (sample_if.drive_frequency),
    .res_valid_i    (result_if.valid),
    .res_ready_i    (result_if.ready),
    .res_median_i   (result_if.median_pressure),
    .res_freq_i     (result_if.new_frequency),
    .res_issued_i   (result_if.command_issued),
    .res_at_target_i(result_if.at_target),
    .fail_count_o   (fail_count),
    .pending_o      (pending_batches),
    .checked_o      (results_checked)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the handshakes hang
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one sample item after a drawn gap, return once it is taken
  task automatic send_sample(input logic signed [RAW_W-1:0] raw, input logic ok,
                             input logic [FREQ_W-1:0] freq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid           <= 1'b1;
    sample_if.raw_pressure    <= raw;
    sample_if.read_ok         <= ok;
    sample_if.drive_frequency <= freq;
    do @(posedge clk_i); while (!sample_if.ready);
    items_sent++;
  endtask

  // write all four registers on consecutive edges, then let the steps settle
  task automatic load_settings(input logic [SET_W-1:0] sp, input logic [FREQ_W-1:0] mf,
                               input logic [THR_W-1:0] thr, input logic [QC_W-1:0] qc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SETPOINT;
    cfg_data_i <= CFG_DATA_W'(sp);
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_FREQ;
    cfg_data_i <= mf;
    @(posedge clk_i);
    cfg_idx_i  <= REG_THRESHOLD;
    cfg_data_i <= CFG_DATA_W'(thr);
    @(posedge clk_i);
    cfg_idx_i  <= REG_QUICK_CHANGE;
    cfg_data_i <= CFG_DATA_W'(qc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_setpoint  = sp;
    cur_max_freq  = mf;
    cur_threshold = thr;
    cur_quick     = qc;
    settings_done++;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // stop offering, wait for every batch result, then let the pipeline drain
  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_batches != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // scaled level a batch clusters around: setpoint, threshold edges or anywhere
  function automatic int pick_center();
    case ($urandom_range(0, 3))
      0:       return cur_setpoint;
      1:       return cur_setpoint + cur_threshold + int'($urandom_range(0, 2)) - 1;
      2:       return cur_setpoint - cur_threshold - int'($urandom_range(0, 2)) + 1;
      default: return int'($urandom_range(0, 272)) - 136;
    endcase
  endfunction

  // raw reading near a scaled level, or plain noise
  function automatic logic signed [RAW_W-1:0] pick_raw(int center);
    int v;
    if ($urandom_range(0, 3) == 0) return RAW_W'($urandom());
    v = center * 253 + int'($urandom_range(0, 240)) - 120;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return RAW_W'(v);
  endfunction

  // readback aimed at the clamp, the large step and the small-decrease corner
  function automatic logic [FREQ_W-1:0] pick_freq();
    int big_step;
    big_step = (cur_max_freq / 100) * cur_quick;
    case ($urandom_range(0, 5))
      0:       return FREQ_W'($urandom());
      1:       return FREQ_W'($urandom_range(0, 200));
      2:       return FREQ_W'(cur_max_freq + int'($urandom_range(0, 600)) - 300);
      3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      4:       return FREQ_W'(big_step + int'($urandom_range(0, 40)) - 20);
      default: return FREQ_W'($urandom_range(0, cur_max_freq));
    endcase
  endfunction

  // result side: random hold-offs per item, long hold-off on request
  initial begin : result_sink
    int gap;
    int stalls_served;
    stalls_served = 0;
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stalls_served != long_stall_req) begin
        gap = LONG_STALL_CYCLES;
        stalls_served++;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  // reset, corner batches, then phases of random batches under changing settings
  initial begin : stimulus
    int   center;
    logic hard_push;
    center = 0;
    rst_ni                    <= 1'b0;
    cfg_we_i                  <= 1'b0;
    cfg_idx_i                 <= REG_SETPOINT;
    cfg_data_i                <= '0;
    sample_if.valid           <= 1'b0;
    sample_if.raw_pressure    <= '0;
    sample_if.read_ok         <= 1'b0;
    sample_if.drive_frequency <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // range ends of every field, median lands on the reset setpoint
    for (int i = 0; i < SAMPLES; i++)
      send_sample(corner_raw[i], corner_ok[i], (i % 2) ? 16'hFFFF : 16'h0000);
    // full-scale high with zero readback: large decrease impossible, small one gives 0
    for (int i = 0; i < SAMPLES; i++) send_sample(16'sh7FFF, 1'b1, 16'h0000);
    // full-scale low with top readback: increase clamps to max_freq
    for (int i = 0; i < SAMPLES; i++) send_sample(16'sh8000, 1'b1, 16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: load_settings(8'd0, 16'hFFFF, 8'd0, 7'd100);
          2: load_settings(8'hFF, 16'd100, 8'hFF, 7'd0);
          3: load_settings(8'd20, 16'd0, 8'd5, 7'd127);
          4: load_settings(8'd0, 16'd101, 8'd0, 7'd127);
          default: load_settings(8'($urandom_range(0, 129)), 16'($urandom_range(100, 65535)),
                                 8'($urandom_range(0, 30)), 7'($urandom_range(0, 127)));
        endcase
      end
      // back-pressure phases: sender runs flat out while the result side holds off
      hard_push = (p == 1 || p == 6);
      if (hard_push) long_stall_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % SAMPLES == 0) begin
          no_idle = hard_push || ($urandom_range(0, 4) == 0);
          center = pick_center();
        end
        send_sample(pick_raw(center), $urandom_range(0, 9) != 0, pick_freq());
      end
    end

    wait_idle();
    $display("%0d sample items under %0d register settings, %0d batch commands compared",
             items_sent, settings_done + 1, results_checked);
    if (fail_count == 0 && pending_batches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/mpfr_pkg.sv
rtl/mpfr_if.sv
rtl/mpfr_front.sv
rtl/mpfr_queue.sv
rtl/mpfr_back.sv
rtl/median_pressure_fan_regulator.sv
sim/mpfr_tb_pkg.sv
sim/mpfr_command_checker.sv
sim/median_pressure_fan_regulator_test.sv
